### sv/mft_pkg.sv
// shared types and constants for the multiturn tracker
package mft_pkg;

	// accumulator width in bits, valid from 24 to 64
	localparam int ACC_WIDTH = 48;

	// width of the clamped scaled magnitude (limit is 2^34)
	localparam int MAG_WIDTH = 35;
	localparam logic [MAG_WIDTH-1:0] MAG_LIMIT = MAG_WIDTH'(64'h4_0000_0000);

	localparam logic signed [31:0] HOME_ANGLE_RESET = 32'sd0;
	localparam logic [39:0] JOINT_SCALE_RESET = 40'h01_0000_0000;
	localparam logic [15:0] WRAP_THRESHOLD_RESET = 16'd41722;
	localparam logic [16:0] TURN_TICKS_RESET = 17'h1_0000;

	localparam int CFG_INDEX_WIDTH = 3;

	typedef logic signed [ACC_WIDTH-1:0] acc_t;
	typedef logic [ACC_WIDTH-1:0] mag_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_HOME_ANGLE     = 3'd0,
		REG_REVERSE        = 3'd1,
		REG_JOINT_SCALE    = 3'd2,
		REG_WRAP_THRESHOLD = 3'd3,
		REG_TURN_TICKS     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] home_angle;
		logic               reverse;
		logic [39:0]        joint_scale;
		logic [15:0]        wrap_threshold;
		logic [16:0]        turn_ticks;
	} cfg_t;

	// per-stage control: pipeline advance and stage occupancy
	typedef struct packed {
		logic adv;
		logic vld;
	} stage_ctl_t;

endpackage

### sv/mft_track.sv
// tick unwrap, saturating accumulator and speed sign handling
module mft_track (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mft_pkg::stage_ctl_t     ctl,
	input  mft_pkg::cfg_t           cfg,
	input  logic [15:0]             speed_s1,
	input  logic [15:0]             encoder_s1,
	output mft_pkg::acc_t           acc_s2,
	output logic signed [15:0]      speed_s2
);
	import mft_pkg::*;

	logic                     first_q;
	logic [15:0]              prev_q;
	acc_t                     acc_q;

	logic signed [16:0]       diff;
	logic signed [16:0]       thr;
	logic signed [18:0]       diff_x;
	logic signed [18:0]       turn;
	logic signed [18:0]       step;
	logic signed [ACC_WIDTH:0] sum;
	acc_t                     acc_sat;
	acc_t                     acc_next;
	logic signed [15:0]       speed_in;
	logic signed [15:0]       speed_dir;

	always_comb begin
		diff   = $signed({1'b0, encoder_s1}) - $signed({1'b0, prev_q});
		thr    = $signed({1'b0, cfg.wrap_threshold});
		diff_x = $signed({{2{diff[16]}}, diff});
		turn   = $signed({2'b00, cfg.turn_ticks});
		if (diff > thr) begin
			step = diff_x - turn;
		end else if (diff < -thr) begin
			step = diff_x + turn;
		end else begin
			step = diff_x;
		end
		sum = $signed({acc_q[ACC_WIDTH-1], acc_q})
			+ $signed({{(ACC_WIDTH + 1 - 19){step[18]}}, step});
		// overflow when the two top bits disagree
		if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
			acc_sat = sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
				: {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end else begin
			acc_sat = sum[ACC_WIDTH-1:0];
		end
		acc_next = first_q ? '0 : acc_sat;
	end

	always_comb begin
		speed_in = $signed(speed_s1);
		if (cfg.reverse) begin
			speed_dir = (speed_in == 16'sh8000) ? 16'sh7fff : -speed_in;
		end else begin
			speed_dir = speed_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			prev_q  <= '0;
			acc_q   <= '0;
		end else if (ctl.adv && ctl.vld) begin
			first_q <= 1'b0;
			prev_q  <= encoder_s1;
			acc_q   <= acc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.vld) begin
			acc_s2   <= acc_next;
			speed_s2 <= speed_dir;
		end
	end

endmodule

### sv/mft_scale.sv
// accumulator to joint radians: magnitude, partial products, combine and clamp
module mft_scale (
	input  logic                        clk,
	input  mft_pkg::stage_ctl_t         ctl_s2,
	input  mft_pkg::stage_ctl_t         ctl_s3,
	input  mft_pkg::stage_ctl_t         ctl_s4,
	input  mft_pkg::cfg_t               cfg,
	input  mft_pkg::acc_t               acc_s2,
	output logic [mft_pkg::MAG_WIDTH-1:0] mag_s5,
	output logic                        neg_s5
);
	import mft_pkg::*;

	// stage 2: absolute value
	mag_t        mag_s3;
	logic        sign_s3;

	// stage 3: partial products
	logic [63:0] m64;
	logic [31:0] ml;
	logic [31:0] mh;
	logic [31:0] sl;
	logic [7:0]  sh;
	logic [63:0] pp_ll_s4;
	logic [39:0] pp_lh_s4;
	logic [63:0] pp_hl_s4;
	logic        hi_s4;
	logic        sign_s4;

	// stage 4: combine
	logic [63:0]          sum;
	logic [MAG_WIDTH-1:0] mag_c;
	logic                 frac;

	always_ff @(posedge clk) begin
		if (ctl_s2.adv && ctl_s2.vld) begin
			sign_s3 <= acc_s2[ACC_WIDTH-1];
			mag_s3  <= acc_s2[ACC_WIDTH-1] ? mag_t'(-acc_s2) : mag_t'(acc_s2);
		end
	end

	always_comb begin
		m64 = 64'(mag_s3);
		ml  = m64[31:0];
		mh  = m64[63:32];
		sl  = cfg.joint_scale[31:0];
		sh  = cfg.joint_scale[39:32];
	end

	always_ff @(posedge clk) begin
		if (ctl_s3.adv && ctl_s3.vld) begin
			pp_ll_s4 <= 64'(ml) * 64'(sl);
			pp_lh_s4 <= 40'(ml) * 40'(sh);
			pp_hl_s4 <= 64'(mh) * 64'(sl);
			hi_s4    <= (mh != '0) && (sh != '0);
			sign_s4  <= sign_s3;
		end
	end

	always_comb begin
		sum  = 64'(pp_ll_s4[63:32]) + 64'(pp_lh_s4) + pp_hl_s4;
		frac = |pp_ll_s4[31:0];
		if (hi_s4 || (pp_hl_s4 >= 64'(MAG_LIMIT))) begin
			mag_c = MAG_LIMIT;
		end else if (sum > 64'(MAG_LIMIT)) begin
			mag_c = MAG_LIMIT;
		end else begin
			mag_c = sum[MAG_WIDTH-1:0];
		end
	end

	// a negative product floors one further from zero when bits were dropped
	always_ff @(posedge clk) begin
		if (ctl_s4.adv && ctl_s4.vld) begin
			mag_s5 <= mag_c + MAG_WIDTH'(sign_s4 & frac);
			neg_s5 <= sign_s4 ^ cfg.reverse;
		end
	end

endmodule

### sv/mft_angle.sv
// offset add, 32-bit saturation and the result register
module mft_angle (
	input  logic                          clk,
	input  mft_pkg::stage_ctl_t           ctl,
	input  logic signed [31:0]            home_angle,
	input  logic [mft_pkg::MAG_WIDTH-1:0] mag_s5,
	input  logic                          neg_s5,
	input  logic signed [15:0]            speed_s5,
	output logic signed [31:0]            angle_q,
	output logic signed [15:0]            speed_q
);
	import mft_pkg::*;

	logic signed [MAG_WIDTH+1:0] q;
	logic signed [MAG_WIDTH+1:0] total;
	logic signed [31:0]          angle_sat;

	always_comb begin
		q     = neg_s5 ? -$signed({2'b00, mag_s5}) : $signed({2'b00, mag_s5});
		total = $signed({{(MAG_WIDTH + 2 - 32){home_angle[31]}}, home_angle}) + q;
		if (total > (MAG_WIDTH+2)'(64'sh7fff_ffff)) begin
			angle_sat = 32'sh7fff_ffff;
		end else if (total < -(MAG_WIDTH+2)'(64'sh8000_0000)) begin
			angle_sat = 32'sh8000_0000;
		end else begin
			angle_sat = total[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.vld) begin
			angle_q <= angle_sat;
			speed_q <= speed_s5;
		end
	end

endmodule

### sv/motor_feedback_multiturn_tracker.sv
// top level of the multiturn motor feedback tracker
// usage:
//   in channel: one transaction per feedback reply (speed_word, encoder_word)
//   out channel: one transaction per reply (joint_angle Q16.16 rad, joint_speed)
//   cfg channel: register index plus data, always ready; write only while idle
//   register map: 0 home_angle, 1 reverse_direction, 2 joint_scale,
//     3 wrap_threshold, 4 turn_ticks; other indexes are dropped
// timing:
//   five-stage pipeline (s1 to s5) feeding the result register
//   throughput one transaction per cycle while not stalled; the scale multiply is split
//   into three partial products in their own stage so the whole chain stays short
// reset:
//   arst_n clears pipeline valids, register file to defaults and the
//   accumulator; the first reply after reset only sets the encoder reference
// backpressure:
//   the whole pipeline advances together; when out_ready is low with a result
//   held, in_ready drops and every stage keeps its contents
module motor_feedback_multiturn_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [15:0]                         speed_word,
	input  logic [15:0]                         encoder_word,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [31:0]                  joint_angle,
	output logic signed [15:0]                  joint_speed,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mft_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [39:0]                         cfg_data
);
	import mft_pkg::*;

	cfg_t cfg_q;

	// pipeline control
	logic adv;
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;
	logic v_s5;
	logic out_valid_q;

	// pipeline payload
	logic [15:0]          speed_s1;
	logic [15:0]          encoder_s1;
	acc_t                 acc_s2;
	logic signed [15:0]   speed_s2;
	logic signed [15:0]   speed_s3;
	logic signed [15:0]   speed_s4;
	logic signed [15:0]   speed_s5;
	logic [MAG_WIDTH-1:0] mag_s5;
	logic                 neg_s5;

	stage_ctl_t ctl_s1;
	stage_ctl_t ctl_s2;
	stage_ctl_t ctl_s3;
	stage_ctl_t ctl_s4;
	stage_ctl_t ctl_s5;

	// single stall point at the result register
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	assign ctl_s1 = '{adv: adv, vld: v_s1};
	assign ctl_s2 = '{adv: adv, vld: v_s2};
	assign ctl_s3 = '{adv: adv, vld: v_s3};
	assign ctl_s4 = '{adv: adv, vld: v_s4};
	assign ctl_s5 = '{adv: adv, vld: v_s5};

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.home_angle     <= HOME_ANGLE_RESET;
			cfg_q.reverse        <= 1'b0;
			cfg_q.joint_scale    <= JOINT_SCALE_RESET;
			cfg_q.wrap_threshold <= WRAP_THRESHOLD_RESET;
			cfg_q.turn_ticks     <= TURN_TICKS_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_HOME_ANGLE:     cfg_q.home_angle     <= $signed(cfg_data[31:0]);
				REG_REVERSE:        cfg_q.reverse        <= cfg_data[0];
				REG_JOINT_SCALE:    cfg_q.joint_scale    <= cfg_data;
				REG_WRAP_THRESHOLD: cfg_q.wrap_threshold <= cfg_data[15:0];
				REG_TURN_TICKS:     cfg_q.turn_ticks     <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	// valid chain, moves only when the output side can take a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			speed_s1   <= speed_word;
			encoder_s1 <= encoder_word;
		end
	end

	// speed rides alongside the angle math
	always_ff @(posedge clk) begin
		if (adv) begin
			speed_s3 <= speed_s2;
			speed_s4 <= speed_s3;
			speed_s5 <= speed_s4;
		end
	end

	mft_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_s1),
		.cfg        (cfg_q),
		.speed_s1   (speed_s1),
		.encoder_s1 (encoder_s1),
		.acc_s2     (acc_s2),
		.speed_s2   (speed_s2)
	);

	mft_scale u_scale (
		.clk    (clk),
		.ctl_s2 (ctl_s2),
		.ctl_s3 (ctl_s3),
		.ctl_s4 (ctl_s4),
		.cfg    (cfg_q),
		.acc_s2 (acc_s2),
		.mag_s5 (mag_s5),
		.neg_s5 (neg_s5)
	);

	mft_angle u_angle (
		.clk        (clk),
		.ctl        (ctl_s5),
		.home_angle (cfg_q.home_angle),
		.mag_s5     (mag_s5),
		.neg_s5     (neg_s5),
		.speed_s5   (speed_s5),
		.angle_q    (joint_angle),
		.speed_q    (joint_speed)
	);

	// an accepted transaction occupies the first stage next cycle
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted transaction missing from first stage");

	// last stage hands over to the result register when the pipe moves
	a_s5_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && adv |=> out_valid)
		else $error("result lost between last stage and output");

	// a stall freezes pipeline occupancy
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5}))
		else $error("pipeline moved during stall");

endmodule

### bench/motor_feedback_multiturn_tracker_tb.sv
// self-checking testbench for the multiturn motor feedback tracker
`timescale 1ns / 1ps

module motor_feedback_multiturn_tracker_tb;
	import mft_pkg::*;

	// delay from an input transaction to its result, which sets the settle time below
	localparam int PIPE_LATENCY = 5;
	localparam int SETTLE_CYCLES = PIPE_LATENCY + 3;
	localparam int unsigned RUN_LIMIT = 200000;
	localparam int PRINT_CAP = 200;

	// first index past the register map, used to check that such writes are dropped
	localparam logic [CFG_INDEX_WIDTH-1:0] FIRST_UNMAPPED_REG = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] LAST_UNMAPPED_REG = 3'd7;

	// saturation bounds of the tick accumulator, the scaled magnitude, the joint angle and the speed
	localparam longint ACC_HI = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam longint ANGLE_MAX = 64'sd2147483647;
	localparam longint ANGLE_MIN = -64'sd2147483648;
	localparam longint unsigned SCALED_CLAMP = 64'h4_0000_0000;
	localparam logic signed [15:0] SPEED_MIN = 16'sh8000;
	localparam logic signed [15:0] SPEED_MAX = 16'sh7FFF;

	// register values used as corners
	localparam logic [39:0] SCALE_UNITY = 40'h01_0000_0000;
	localparam logic [39:0] SCALE_FULL = 40'hFF_FFFF_FFFF;
	localparam logic [15:0] WRAP_DEFAULT = 16'd41722;
	localparam logic [16:0] TURN_DEFAULT = 17'h1_0000;
	localparam logic [16:0] TURN_FULL = 17'h1_FFFF;

	typedef struct {
		logic [15:0] speed;
		logic [15:0] encoder;
	} feedback_t;

	typedef struct {
		logic [CFG_INDEX_WIDTH-1:0] index;
		logic [39:0]                data;
	} reg_write_t;

	typedef struct {
		logic signed [31:0] angle;
		logic signed [15:0] speed;
	} joint_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] speed_word = '0;
	logic [15:0] encoder_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] joint_angle;
	logic signed [15:0] joint_speed;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [39:0] cfg_data = '0;

	// mirror of the register file, updated as each write transaction lands
	logic signed [31:0] home_angle_q = '0;
	logic reverse_q = 1'b0;
	logic [39:0] scale_q = SCALE_UNITY;
	logic [15:0] wrap_q = WRAP_DEFAULT;
	logic [16:0] turn_q = TURN_DEFAULT;

	// mirror of the tracking state
	logic awaiting_first = 1'b1;
	logic [15:0] prev_ticks = '0;
	longint acc_ticks = 0;

	feedback_t feedback_pending[$];
	reg_write_t write_pending[$];
	joint_state_t expected_joint[$];
	feedback_t feedback_driven;
	reg_write_t write_driven;

	// idle rates in percent of cycles for the sender and the receiver
	int unsigned send_idle_pct = 32;
	int unsigned recv_idle_pct = 49;

	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	int unsigned items_accepted = 0;
	int unsigned writes_accepted = 0;
	int unsigned results_checked = 0;

	logic [15:0] enc_pos = '0;

	motor_feedback_multiturn_tracker DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.speed_word  (speed_word),
		.encoder_word(encoder_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.joint_angle (joint_angle),
		.joint_speed (joint_speed),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (error_count < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// register write as the block sees it: each field keeps only its own width
	function automatic void apply_write(input reg_write_t wr);
		case (wr.index)
			REG_HOME_ANGLE:     home_angle_q = wr.data[31:0];
			REG_REVERSE:        reverse_q = wr.data[0];
			REG_JOINT_SCALE:    scale_q = wr.data;
			REG_WRAP_THRESHOLD: wrap_q = wr.data[15:0];
			REG_TURN_TICKS:     turn_q = wr.data[16:0];
			default: ;
		endcase
	endfunction

	// advances the tracking state by one reply and returns the joint it reports
	function automatic joint_state_t track_joint(input feedback_t fb);
		logic signed [15:0] spd;
		longint delta, q, angle;
		longint unsigned mag_in, m_hi, m_lo, s_hi, s_lo, low, mag, mid;
		logic neg, frac;
		joint_state_t res;

		spd = fb.speed;
		// negating the most negative speed pins it at the top
		if (reverse_q) spd = (spd == SPEED_MIN) ? SPEED_MAX : -spd;

		if (awaiting_first) begin
			prev_ticks = fb.encoder;
			acc_ticks = 0;
			awaiting_first = 1'b0;
		end else begin
			delta = longint'(fb.encoder) - longint'(prev_ticks);
			// one turn removed or added once the step passes the threshold
			if (delta > longint'(wrap_q)) delta = delta - longint'(turn_q);
			else if (delta < -longint'(wrap_q)) delta = delta + longint'(turn_q);
			prev_ticks = fb.encoder;
			if (delta > 0 && acc_ticks > ACC_HI - delta) acc_ticks = ACC_HI;
			else if (delta < 0 && acc_ticks < ACC_LO - delta) acc_ticks = ACC_LO;
			else acc_ticks = acc_ticks + delta;
		end

		// sign-magnitude product, floored toward minus infinity, magnitude clamped
		neg = (acc_ticks < 0);
		mag_in = neg ? -acc_ticks : acc_ticks;
		m_lo = mag_in & 64'hFFFF_FFFF;
		m_hi = mag_in >> 32;
		s_lo = 64'(scale_q[31:0]);
		s_hi = 64'(scale_q[39:32]);
		low = m_lo * s_lo;
		mag = (low >> 32) + m_lo * s_hi;
		frac = (low[31:0] != 32'd0);
		mid = m_hi * s_lo;
		if ((m_hi != 0 && s_hi != 0) || mid >= SCALED_CLAMP) begin
			mag = SCALED_CLAMP;
		end else begin
			mag = mag + mid;
			if (mag > SCALED_CLAMP) mag = SCALED_CLAMP;
		end
		q = neg ? -longint'(mag) - longint'(frac) : longint'(mag);
		if (reverse_q) q = -q;

		angle = longint'(home_angle_q) + q;
		if (angle > ANGLE_MAX) angle = ANGLE_MAX;
		if (angle < ANGLE_MIN) angle = ANGLE_MIN;

		res.angle = angle[31:0];
		res.speed = spd;
		return res;
	endfunction

	// driver: feeds the input and register channels from their queues
	always @(posedge clk) begin
		cycle_count++;

		// input transaction lands: predict its result now
		if (in_valid && in_ready) begin
			expected_joint.push_back(track_joint(feedback_driven));
			items_accepted++;
		end
		// the slot is free when nothing is offered or the offer was just taken
		if (!in_valid || in_ready) begin
			if (feedback_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				feedback_driven = feedback_pending.pop_front();
				in_valid <= 1'b1;
				speed_word <= feedback_driven.speed;
				encoder_word <= feedback_driven.encoder;
			end else begin
				in_valid <= 1'b0;
			end
		end

		// register write transaction lands
		if (cfg_valid && cfg_ready) begin
			apply_write(write_driven);
			writes_accepted++;
		end
		if (!cfg_valid || cfg_ready) begin
			if (write_pending.size() > 0) begin
				write_driven = write_pending.pop_front();
				cfg_valid <= 1'b1;
				cfg_index <= write_driven.index;
				cfg_data <= write_driven.data;
			end else begin
				cfg_valid <= 1'b0;
			end
		end

		if (cycle_count >= RUN_LIMIT) begin
			$display("motor_feedback_multiturn_tracker_tb: errors");
			$finish;
		end
	end

	// monitor: checks each result transaction against the oldest prediction
	always @(posedge clk) begin
		joint_state_t exp_joint;
		if (arst_n && out_valid && out_ready) begin
			if (expected_joint.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, angle %0d speed %0d",
					joint_angle, joint_speed));
			end else begin
				exp_joint = expected_joint.pop_front();
				if (joint_angle !== exp_joint.angle)
					report_mismatch($sformatf("joint_angle %0d, expected %0d",
						joint_angle, exp_joint.angle));
				if (joint_speed !== exp_joint.speed)
					report_mismatch($sformatf("joint_speed %0d, expected %0d",
						joint_speed, exp_joint.speed));
				results_checked++;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic push_feedback(input logic [15:0] spd, input logic [15:0] enc);
		feedback_t fb;
		fb.speed = spd;
		fb.encoder = enc;
		feedback_pending.push_back(fb);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [39:0] data);
		reg_write_t wr;
		wr.index = idx;
		wr.data = data;
		write_pending.push_back(wr);
	endtask

	// block idle: every queue drained, every result back, pipeline given time to empty
	task automatic wait_idle();
		while (feedback_pending.size() > 0 || in_valid || expected_joint.size() > 0 ||
				write_pending.size() > 0 || cfg_valid)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// speeds lean on the corners so the negation edge comes up often
	function automatic logic [15:0] pick_speed();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int n_items;
		int r;
		int big;
		logic [39:0] value;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, default registers: first sample, threshold edges, field corners
		push_feedback(16'h0000, 16'd0);
		push_feedback(16'h7FFF, 16'd41722);
		push_feedback(16'h8000, 16'd0);
		push_feedback(16'hFFFF, 16'd41723);
		push_feedback(16'h0001, 16'd0);
		push_feedback(16'h8000, 16'hFFFF);
		push_feedback(16'h7FFF, 16'h0000);
		push_feedback(16'h0000, 16'h8000);
		push_feedback(16'hFFFF, 16'hFFFF);
		push_feedback(16'hAAAA, 16'h5555);
		push_feedback(16'h5555, 16'hAAAA);
		wait_idle();

		// reversed direction with the top offset; junk above each field must be dropped
		write_reg(REG_REVERSE, {$urandom, 7'($urandom), 1'b1});
		write_reg(REG_HOME_ANGLE, {8'($urandom), 32'h7FFF_FFFF});
		write_reg(CFG_INDEX_WIDTH'($urandom_range(LAST_UNMAPPED_REG, FIRST_UNMAPPED_REG)),
			{8'($urandom), 32'($urandom)});
		wait_idle();
		push_feedback(16'h8000, 16'h0123);
		push_feedback(16'h7FFF, 16'h4567);
		push_feedback(16'h0000, 16'hFEDC);
		push_feedback(16'hFFFF, 16'h0000);
		wait_idle();

		// later offset write shifts the angle right away
		write_reg(REG_HOME_ANGLE, {8'($urandom), 32'h8000_0000});
		wait_idle();
		push_feedback(16'h8000, 16'h0000);
		push_feedback(16'h1234, 16'h0F0F);
		wait_idle();
		enc_pos = 16'h0F0F;

		for (int phase = 0; phase < 9; phase++) begin
			if (phase == 4) begin
				// idle rates swap for the ramp part
				send_idle_pct = 49;
				recv_idle_pct = 32;
				// ramps: widest turn with the smallest threshold gives the largest step,
				// which drives the product into the magnitude clamp and both angle rails
				write_reg(REG_TURN_TICKS, {23'($urandom), TURN_FULL});
				write_reg(REG_WRAP_THRESHOLD, {24'($urandom), 16'd1});
				write_reg(REG_JOINT_SCALE, SCALE_FULL);
				write_reg(REG_HOME_ANGLE, {8'($urandom), 32'($urandom)});
				for (int ramp = 0; ramp < 4; ramp++) begin
					write_reg(REG_REVERSE, {39'd0, ramp[0]});
					wait_idle();
					for (int k = 0; k < 280; k++) begin
						if ($urandom_range(99) < 3) enc_pos = 16'($urandom);
						else if (ramp < 2) enc_pos = enc_pos - 16'($urandom_range(5, 2));
						else enc_pos = enc_pos + 16'($urandom_range(5, 2));
						push_feedback(pick_speed(), enc_pos);
					end
					wait_idle();
				end
				// remaining stretches run with no idling at all
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			// fresh register setting for this stretch, corners mixed with random values
			case ($urandom_range(3))
				0: value = 40'h00_8000_0000;
				1: value = 40'h00_7FFF_FFFF;
				2: value = '0;
				default: value = 40'($urandom);
			endcase
			write_reg(REG_HOME_ANGLE, {8'($urandom), value[31:0]});
			write_reg(REG_REVERSE, {$urandom, 8'($urandom_range(255))});
			case ($urandom_range(4))
				0: value = '0;
				1: value = SCALE_FULL;
				2: value = SCALE_UNITY;
				3: value = {8'($urandom), 32'($urandom)};
				default: value = 40'($urandom_range(32'h0FFF_FFFF));
			endcase
			write_reg(REG_JOINT_SCALE, value);
			case ($urandom_range(4))
				0: value = '0;
				1: value = 40'd1;
				2: value = 40'hFFFF;
				3: value = 40'(WRAP_DEFAULT);
				default: value = 40'($urandom);
			endcase
			write_reg(REG_WRAP_THRESHOLD, {24'($urandom), value[15:0]});
			case ($urandom_range(4))
				0: value = '0;
				1: value = 40'd1;
				2: value = 40'(TURN_DEFAULT);
				3: value = 40'(TURN_FULL);
				default: value = 40'($urandom);
			endcase
			write_reg(REG_TURN_TICKS, {23'($urandom), value[16:0]});
			if ($urandom_range(99) < 30)
				write_reg(CFG_INDEX_WIDTH'($urandom_range(LAST_UNMAPPED_REG, FIRST_UNMAPPED_REG)),
					{8'($urandom), 32'($urandom)});
			wait_idle();

			// encoder walk: mostly small steps, some large ones near a turn, some noise
			n_items = $urandom_range(70, 40);
			for (int k = 0; k < n_items; k++) begin
				r = $urandom_range(99);
				if (r < 70) begin
					enc_pos = enc_pos + 16'($urandom_range(6000)) - 16'd3000;
				end else if (r < 85) begin
					big = $urandom_range(45000, 20000);
					enc_pos = $urandom_range(1) ? enc_pos + 16'(big) : enc_pos - 16'(big);
				end else begin
					enc_pos = 16'($urandom);
				end
				push_feedback(pick_speed(), enc_pos);
			end
			wait_idle();
		end

		$display("summary: %0d feedback transactions, %0d register writes, %0d results checked",
			items_accepted, writes_accepted, results_checked);
		$display("summary: default, reversed and corner settings, turn unwrap and saturation ramps");
		if (error_count == 0) begin
			$display("motor_feedback_multiturn_tracker_tb: clean");
		end else begin
			$display("motor_feedback_multiturn_tracker_tb: errors");
		end
		$finish;
	end

endmodule
